>>> hdl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/hotp_pkg.sv
// ----------------------------------------------------------------------------
// hotp_pkg
// Types and constants shared by the HOTP checker modules.
// ----------------------------------------------------------------------------
package hotp_pkg;

   typedef struct packed {
      logic [63:0] first_counter;
      logic [3:0]  tries;
      logic [19:0] candidate_code;
   } req_type;

   typedef struct packed {
      logic        valid_res;
      logic [2:0]  matched_offset;
      logic [19:0] computed_code;
   } rsp_type;

   localparam logic [0:0] CSR_KEY_HIGH = 1'd0;
   localparam logic [0:0] CSR_KEY_LOW  = 1'd1;

   localparam logic [7:0] IPAD_BYTE = 8'h36;
   localparam logic [7:0] OPAD_BYTE = 8'h5c;

   localparam logic [159:0] SHA1_IV =
      160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

   // Block selector: which of the four compressions of one HMAC runs
   localparam logic [1:0] BLK_IPAD  = 2'd0;
   localparam logic [1:0] BLK_INNER = 2'd1;
   localparam logic [1:0] BLK_OPAD  = 2'd2;
   localparam logic [1:0] BLK_OUTER = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       load;       // latch request payload
      logic       blk_start;  // load schedule and working vars for block blk
      logic [1:0] blk;
      logic       round;      // run one SHA-1 round
      logic       blk_end;    // fold working vars into chaining value
      logic       trunc;      // dynamic truncation of the digest
      logic       mod_start;  // start modulo reduction
      logic       mod_step;   // one reduction step (quotient times modulus, subtract, correct)
      logic       next_ctr;   // advance to next counter
   } cmd_type;

   typedef struct packed {
      logic round_last;
      logic mod_last;
      logic match;
      logic last_try;
   } sts_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

endpackage

>>> hdl/hotp_datapath.sv
// ----------------------------------------------------------------------------
// hotp_datapath
// SHA-1 round engine with rolling message schedule, HMAC block formatting,
// dynamic truncation and a reciprocal-multiply modulo reducer.
// ----------------------------------------------------------------------------
module hotp_datapath #(
   parameter int MAX_TRIES    = 8,
   parameter int CODE_MODULUS = 1000000
) (
   input  logic                  clock,
   input  logic [15:0]           key_high,
   input  logic [63:0]           key_low,
   input  hotp_pkg::req_type     req_data,
   input  hotp_pkg::cmd_type     cmd,
   output hotp_pkg::sts_type     sts,
   output hotp_pkg::rsp_type     result
);
   localparam int OFS_W = (MAX_TRIES > 1) ? $clog2(MAX_TRIES) : 1;
   localparam int MOD_W = $clog2(CODE_MODULUS + 1);
   localparam logic [31:0] MOD32 = 32'(CODE_MODULUS);
   // floor(2^32 / modulus): quotient estimate is low by at most one
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(CODE_MODULUS));

   logic [63:0]  ctr_ff;
   logic [6:0]   tries_ff;
   logic [19:0]  cand_ff;
   logic [OFS_W-1:0] ofs_ff;
   logic [159:0] h_ff, inner_ff;
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  w_ff [16];
   logic [6:0]   rnd_ff;
   logic         mcnt_ff;
   logic [30:0]  trunc_ff;
   logic [62:0]  prod_ff;
   logic [31:0]  qm_ff;
   logic [MOD_W-1:0] code_ff;

   // key padded to 512 bits
   logic [511:0] keyblk, padblk, msgblk;
   assign keyblk = {key_high, key_low, 432'd0};

   always_comb begin
      padblk = '0;
      for (int i = 0; i < 64; i++) begin
         padblk[8*i +: 8] = keyblk[8*i +: 8] ^
                            ((cmd.blk == hotp_pkg::BLK_IPAD) ? hotp_pkg::IPAD_BYTE
                                                            : hotp_pkg::OPAD_BYTE);
      end
      unique case (cmd.blk)
         hotp_pkg::BLK_IPAD, hotp_pkg::BLK_OPAD: msgblk = padblk;
         // counter, 0x80, length 576 bits
         hotp_pkg::BLK_INNER: msgblk = {ctr_ff, 8'h80, 376'd0, 64'd576};
         // inner digest, 0x80, length 672 bits
         default: msgblk = {inner_ff, 8'h80, 280'd0, 64'd672};
      endcase
   end

   // round logic
   logic [31:0] f, k, t, wnew, wcur;
   assign wcur = w_ff[0];
   assign wnew = hotp_pkg::rotl(w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0], 5'd1);
   always_comb begin
      priority if (rnd_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff); k = 32'h5A827999;
      end else if (rnd_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff; k = 32'h6ED9EBA1;
      end else if (rnd_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff); k = 32'h8F1BBCDC;
      end else begin
         f = b_ff ^ c_ff ^ d_ff; k = 32'hCA62C1D6;
      end
      t = hotp_pkg::rotl(a_ff, 5'd5) + f + e_ff + k + wcur;
   end

   logic [159:0] hsum, hstart;
   assign hsum = {h_ff[159:128] + a_ff, h_ff[127:96] + b_ff, h_ff[95:64] + c_ff,
                  h_ff[63:32] + d_ff, h_ff[31:0] + e_ff};
   assign hstart = (cmd.blk == hotp_pkg::BLK_IPAD || cmd.blk == hotp_pkg::BLK_OPAD)
                   ? hotp_pkg::SHA1_IV : h_ff;

   // truncation of the outer digest (held in h_ff)
   logic [3:0]  toff;
   logic [31:0] tword;
   assign toff  = h_ff[3:0];
   assign tword = h_ff[159 - 8*toff -: 32];

   // remainder candidate lies in [0, 2 * modulus)
   logic [31:0] mdiff, mfix;
   assign mdiff = {1'b0, trunc_ff} - qm_ff;
   assign mfix  = (mdiff >= MOD32) ? (mdiff - MOD32) : mdiff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ctr_ff   <= req_data.first_counter;
         cand_ff  <= req_data.candidate_code;
         ofs_ff   <= '0;
         if (req_data.tries == 4'd0)
            tries_ff <= 7'd1;
         else if (7'(req_data.tries) > 7'(MAX_TRIES))
            tries_ff <= 7'(MAX_TRIES);
         else
            tries_ff <= 7'(req_data.tries);
      end
      if (cmd.next_ctr) begin
         ctr_ff <= ctr_ff + 64'd1;
         ofs_ff <= ofs_ff + OFS_W'(1);
      end
      if (cmd.blk_start) begin
         for (int i = 0; i < 16; i++) w_ff[i] <= msgblk[511 - 32*i -: 32];
         {a_ff, b_ff, c_ff, d_ff, e_ff} <= hstart;
         h_ff   <= hstart;
         rnd_ff <= '0;
      end else if (cmd.round) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= wnew;
         e_ff <= d_ff; d_ff <= c_ff; c_ff <= hotp_pkg::rotl(b_ff, 5'd30);
         b_ff <= a_ff; a_ff <= t;
         rnd_ff <= rnd_ff + 7'd1;
      end
      if (cmd.blk_end) begin
         h_ff <= hsum;
         if (cmd.blk == hotp_pkg::BLK_INNER) inner_ff <= hsum;
      end
      if (cmd.trunc) trunc_ff <= tword[30:0];
      if (cmd.mod_start) begin
         prod_ff <= {32'd0, trunc_ff} * {31'd0, RECIP};
         mcnt_ff <= 1'b0;
      end else if (cmd.mod_step) begin
         // quotient times modulus, then subtract and correct once
         qm_ff   <= {1'b0, prod_ff[62:32]} * MOD32;
         code_ff <= MOD_W'(mfix);
         mcnt_ff <= 1'b1;
      end
   end

   logic [6:0] ofs_next;
   assign ofs_next = 7'(ofs_ff) + 7'd1;

   assign sts.round_last = (rnd_ff == 7'd79);
   assign sts.mod_last   = mcnt_ff;
   assign sts.match      = ({{(64-MOD_W){1'b0}}, code_ff} == {44'd0, cand_ff});
   assign sts.last_try   = (ofs_next >= tries_ff);

   assign result.valid_res      = sts.match;
   assign result.matched_offset = sts.match ? 3'(ofs_ff) : 3'd0;
   assign result.computed_code  = 20'(code_ff);
endmodule

>>> hdl/hotp_ctrl.sv
// ----------------------------------------------------------------------------
// hotp_ctrl
// Sequencer: four 80-round compressions per counter, truncation, reduction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module hotp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hotp_pkg::cmd_type cmd,
   input  hotp_pkg::sts_type sts
);
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_START = 4'd1;
   localparam logic [3:0] ST_ROUND = 4'd2;
   localparam logic [3:0] ST_TRUNC = 4'd3;
   localparam logic [3:0] ST_MOD0  = 4'd4;
   localparam logic [3:0] ST_MOD   = 4'd5;
   localparam logic [3:0] ST_CHECK = 4'd6;
   localparam logic [3:0] ST_DONE  = 4'd7;
   localparam logic [3:0] ST_FOLD  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [1:0] blk_ff, blk_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

   always_comb begin
      state_in = state_ff;
      blk_in   = blk_ff;
      cmd      = '0;
      cmd.blk  = blk_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               blk_in   = hotp_pkg::BLK_IPAD;
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.blk_start = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (sts.round_last) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            // fold working vars into the chaining value, then next block or truncation
            cmd.blk_end = 1'b1;
            blk_in      = blk_ff + 2'd1;
            if (blk_ff == hotp_pkg::BLK_OUTER) state_in = ST_TRUNC;
            else                               state_in = ST_START;
         end
         ST_TRUNC: begin
            cmd.trunc = 1'b1;
            state_in  = ST_MOD0;
         end
         ST_MOD0: begin
            cmd.mod_start = 1'b1;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_last) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.match || sts.last_try) begin
               state_in = ST_DONE;
            end else begin
               cmd.next_ctr = 1'b1;
               blk_in   = hotp_pkg::BLK_IPAD;
               state_in = ST_START;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         blk_ff   <= hotp_pkg::BLK_IPAD;
      end else begin
         state_ff <= state_in;
         blk_ff   <= blk_in;
      end
   end

   `ASSERT_IMP(a_no_req_when_busy, clock, reset, state_ff != ST_IDLE, req_stall,
               "request taken while busy")
   `ASSERT_NXT(a_done_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid,
               "result dropped under stall")
   `ASSERT_IMP(a_one_phase, clock, reset, 1'b1,
               $countones({cmd.round, cmd.blk_start, cmd.blk_end, cmd.mod_step}) <= 1,
               "conflicting datapath commands")
endmodule

>>> hdl/hotp_hmac_sha1_checker.sv
// HOTP checker: each request takes up to (tries) counters through HMAC-SHA1,
// clamped to 1..MAX_TRIES and stopping at a match, each counter costing four
// SHA-1 compressions of a block load, 80 rounds at one round per cycle and a
// fold, then truncation, a reciprocal-multiply modulo reduction and a check.
// The result is held while stalled; the single shared round engine serves one
// counter at a time. One request is in flight at a time.
// ----------------------------------------------------------------------------
// hotp_hmac_sha1_checker
// Top level: key registers, controller and datapath.
// ----------------------------------------------------------------------------
module hotp_hmac_sha1_checker #(
   parameter int MAX_TRIES    = 8,
   parameter int CODE_MODULUS = 1000000
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [0:0]        csr_index,
   input  logic [63:0]       csr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  hotp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hotp_pkg::rsp_type rsp_data
);
   logic [15:0] key_high_ff;
   logic [63:0] key_low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            hotp_pkg::CSR_KEY_HIGH: key_high_ff <= csr_data[15:0];
            default:                key_low_ff  <= csr_data;
         endcase
      end
   end

   hotp_pkg::cmd_type cmd;
   hotp_pkg::sts_type sts;

   hotp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .sts
   );

   hotp_datapath #(.MAX_TRIES(MAX_TRIES), .CODE_MODULUS(CODE_MODULUS)) u_dp (
      .clock, .key_high(key_high_ff), .key_low(key_low_ff),
      .req_data, .cmd, .sts, .result(rsp_data)
   );
endmodule
